>>> hw/rtl/boundary_set_id_assigner_defines.svh
// assertion macros for the boundary set id assigner
// used by the top level only, no other dependencies
`ifndef BOUNDARY_SET_ID_ASSIGNER_DEFINES_SVH
`define BOUNDARY_SET_ID_ASSIGNER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define BSIA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsia assertion failed");
// next-cycle implication, disabled during reset
`define BSIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsia assertion failed");
`else
`define BSIA_ASSERT_NOW(label, clk, rst, ante, cons)
`define BSIA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/bsia_pkg.sv
// shared types and constants for the boundary set id assigner
// no dependencies
`timescale 1ns / 1ps

package bsia_pkg;

   // default sizing and fixed field widths
   localparam int MAX_NEIGHBORS_DEF = 8;
   localparam int TABLE_DEPTH_DEF   = 256;
   localparam int ID_W              = 16;

   // controller states
   typedef enum logic [1:0] {
      ST_GATHER,
      ST_CLOSE,
      ST_SEARCH
   } state_type;

   // result kinds issued by the controller
   typedef enum logic [2:0] {
      RESP_IDLE,
      RESP_SKIP,
      RESP_HIT,
      RESP_NEW,
      RESP_FULL
   } resp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic     accept;
      logic     scan_clear;
      logic     scan_issue;
      resp_type respond;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic set_ge2;
      logic scan_done;
      logic rd_valid;
      logic rd_match;
      logic table_full;
   } status_type;

endpackage

>>> hw/rtl/boundary_set_id_assigner.sv
// Neighbour items that do not close a neighbourhood are taken one per cycle; after a
// closing item busy stays high while the table is scanned, one stored entry per cycle
// through a registered read port. The result strobe is registered: for sets below two ids
// it follows the close state, otherwise the search state on a hit or a miss, and busy
// drops in the cycle the strobe rises. The receiver cannot stall.
// Synchronous reset empties the table and gathering state, no sweep.
`timescale 1ns / 1ps
`include "boundary_set_id_assigner_defines.svh"

module boundary_set_id_assigner #(
   parameter int MAX_NEIGHBORS = bsia_pkg::MAX_NEIGHBORS_DEF,
   parameter int TABLE_DEPTH   = bsia_pkg::TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [bsia_pkg::ID_W-1:0]  req_neighbor_id,
   input  logic                       req_present,
   input  logic                       req_last,
   output logic                       rsp_valid,
   output logic [bsia_pkg::ID_W-1:0]  rsp_new_state,
   output logic                       rsp_write_cell,
   output logic                       rsp_table_full,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bsia_pkg::ID_W-1:0]  csr_data
);
   import bsia_pkg::*;

   cmd_type    cmd;
   status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencing
   bsia_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // gathering, table and results
   bsia_datapath #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .TABLE_DEPTH   (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_neighbor_id (req_neighbor_id),
      .req_present     (req_present),
      .csr_wr          (csr_valid && csr_ready),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_new_state   (rsp_new_state),
      .rsp_write_cell  (rsp_write_cell),
      .rsp_table_full  (rsp_table_full)
   );

   // checks
   `BSIA_ASSERT_NEXT(a_close_goes_busy, clock, reset, start && !busy && req_last, busy)
   `BSIA_ASSERT_NOW(a_rsp_not_write_and_full, clock, reset, rsp_valid, !(rsp_write_cell && rsp_table_full))
   `BSIA_ASSERT_NEXT(a_hit_writes_cell, clock, reset, cmd.respond == RESP_HIT, rsp_valid && rsp_write_cell)
   `BSIA_ASSERT_NOW(a_rsp_leaves_idle, clock, reset, rsp_valid, !busy)

endmodule

>>> hw/rtl/bsia_ctrl.sv
// controller state machine: gathering, closing and table search sequencing
// depends on bsia_pkg
`timescale 1ns / 1ps

module bsia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_last,
   input  bsia_pkg::status_type  status,
   output bsia_pkg::cmd_type     cmd,
   output logic                  busy
);
   import bsia_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_GATHER;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.scan_clear = 1'b0;
      cmd.scan_issue = 1'b0;
      cmd.respond    = RESP_IDLE;
      busy           = 1'b1;
      unique case (state_ff)
         ST_GATHER: begin
            busy       = 1'b0;
            cmd.accept = start;
            if (start && req_last) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            // set is final here, rewind the scan pointer
            cmd.scan_clear = 1'b1;
            if (!status.set_ge2) begin
               cmd.respond = RESP_SKIP;
               state_in    = ST_GATHER;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // one read issued per cycle until the scan is done, compared in the next cycle
            cmd.scan_issue = !status.scan_done;
            priority if (status.rd_valid && status.rd_match) begin
               cmd.respond = RESP_HIT;
               state_in    = ST_GATHER;
            end else if (status.scan_done && !status.rd_valid) begin
               cmd.respond = status.table_full ? RESP_FULL : RESP_NEW;
               state_in    = ST_GATHER;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         default: begin
            state_in = ST_GATHER;
         end
      endcase
   end

endmodule

>>> hw/rtl/bsia_datapath.sv
// datapath: sorted id gathering, set table memory, compare and result registers
// depends on bsia_pkg
`timescale 1ns / 1ps

module bsia_datapath #(
   parameter int MAX_NEIGHBORS = bsia_pkg::MAX_NEIGHBORS_DEF,
   parameter int TABLE_DEPTH   = bsia_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bsia_pkg::cmd_type            cmd,
   output bsia_pkg::status_type         status,
   input  logic [bsia_pkg::ID_W-1:0]    req_neighbor_id,
   input  logic                         req_present,
   input  logic                         csr_wr,
   input  logic [bsia_pkg::ID_W-1:0]    csr_data,
   output logic                         rsp_valid,
   output logic [bsia_pkg::ID_W-1:0]    rsp_new_state,
   output logic                         rsp_write_cell,
   output logic                         rsp_table_full
);
   import bsia_pkg::*;

   localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
   localparam int EUW = $clog2(TABLE_DEPTH + 1);
   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // configuration
   logic [ID_W-1:0] grain_limit_ff;

   // gathering state
   logic [MAX_NEIGHBORS-1:0][ID_W-1:0] ids_ff, ids_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      items_ff, items_in;

   // table state and search
   logic [MAX_NEIGHBORS-1:0][ID_W-1:0] members_mem [TABLE_DEPTH];
   logic [CW-1:0]                      sizes_mem [TABLE_DEPTH];
   logic [EUW-1:0]                     used_ff, used_in;
   logic [EUW-1:0]                     scan_ff, scan_in;
   logic [EUW-1:0]                     rd_idx_ff;
   logic                               rd_valid_ff;
   logic [MAX_NEIGHBORS-1:0][ID_W-1:0] rd_members_ff;
   logic [CW-1:0]                      rd_size_ff;

   // result registers
   logic            rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] new_state_ff, new_state_in;
   logic            write_ff, write_in;
   logic            full_ff, full_in;

   // insertion helpers
   logic [MAX_NEIGHBORS-1:0]           lt;
   logic [MAX_NEIGHBORS:0]             lt_ext;
   logic [MAX_NEIGHBORS-1:0]           eq;
   logic [MAX_NEIGHBORS-1:0][ID_W-1:0] ids_sh;
   logic                               do_insert;
   logic                               lanes_ok;
   logic                               append;

   // compare each held id against the incoming one
   always_comb begin
      for (int k = 0; k < MAX_NEIGHBORS; k++) begin
         lt[k] = (CW'(k) < count_ff) && (ids_ff[k] < req_neighbor_id);
         eq[k] = (CW'(k) < count_ff) && (ids_ff[k] == req_neighbor_id);
      end
      lt_ext    = {lt, 1'b1};
      ids_sh[0] = req_neighbor_id;
      for (int k = 1; k < MAX_NEIGHBORS; k++) begin
         ids_sh[k] = ids_ff[k-1];
      end
      do_insert = cmd.accept && (items_ff < CW'(MAX_NEIGHBORS)) && req_present &&
                  (req_neighbor_id <= grain_limit_ff) && !(|eq) &&
                  (count_ff < CW'(MAX_NEIGHBORS));
   end

   // sorted insert: keep lower ids, place new id, shift the rest up
   always_comb begin
      ids_in = ids_ff;
      if (do_insert) begin
         for (int k = 0; k < MAX_NEIGHBORS; k++) begin
            if (lt[k]) begin
               ids_in[k] = ids_ff[k];
            end else if (lt_ext[k]) begin
               ids_in[k] = req_neighbor_id;
            end else begin
               ids_in[k] = ids_sh[k];
            end
         end
      end
   end

   // match of the registered table row against the gathered set
   always_comb begin
      lanes_ok = 1'b1;
      for (int k = 0; k < MAX_NEIGHBORS; k++) begin
         if ((CW'(k) < count_ff) && (rd_members_ff[k] != ids_ff[k])) begin
            lanes_ok = 1'b0;
         end
      end
   end

   assign status.set_ge2    = (count_ff >= CW'(2));
   assign status.scan_done  = (scan_ff == used_ff);
   assign status.rd_valid   = rd_valid_ff;
   assign status.rd_match   = lanes_ok && (rd_size_ff == count_ff);
   assign status.table_full = (used_ff == EUW'(TABLE_DEPTH));

   assign append = (cmd.respond == RESP_NEW);

   // counters and result next values
   always_comb begin
      count_in     = count_ff;
      items_in     = items_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      rsp_valid_in = 1'b0;
      new_state_in = new_state_ff;
      write_in     = write_ff;
      full_in      = full_ff;
      if (cmd.accept && (items_ff < CW'(MAX_NEIGHBORS))) begin
         items_in = items_ff + CW'(1);
      end
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_issue) begin
         scan_in = scan_ff + EUW'(1);
      end
      unique case (cmd.respond)
         RESP_IDLE: begin
         end
         RESP_SKIP: begin
            rsp_valid_in = 1'b1;
            new_state_in = '0;
            write_in     = 1'b0;
            full_in      = 1'b0;
         end
         RESP_HIT: begin
            rsp_valid_in = 1'b1;
            new_state_in = grain_limit_ff + ID_W'(1) + ID_W'(rd_idx_ff);
            write_in     = 1'b1;
            full_in      = 1'b0;
         end
         RESP_NEW: begin
            rsp_valid_in = 1'b1;
            new_state_in = grain_limit_ff + ID_W'(1) + ID_W'(used_ff);
            write_in     = 1'b1;
            full_in      = 1'b0;
            used_in      = used_ff + EUW'(1);
         end
         RESP_FULL: begin
            rsp_valid_in = 1'b1;
            new_state_in = '0;
            write_in     = 1'b0;
            full_in      = 1'b1;
         end
         default: begin
         end
      endcase
      // neighbourhood closes with every result transfer
      if (cmd.respond != RESP_IDLE) begin
         count_in = '0;
         items_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grain_limit_ff <= '0;
         count_ff       <= '0;
         items_ff       <= '0;
         used_ff        <= '0;
         scan_ff        <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr) begin
            grain_limit_ff <= csr_data;
         end
         count_ff     <= count_in;
         items_ff     <= items_in;
         used_ff      <= used_in;
         scan_ff      <= scan_in;
         rd_valid_ff  <= cmd.scan_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ids_ff       <= ids_in;
      new_state_ff <= new_state_in;
      write_ff     <= write_in;
      full_ff      <= full_in;
   end

   // set table: one write port for appends, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (append) begin
         members_mem[used_ff[AW-1:0]] <= ids_ff;
         sizes_mem[used_ff[AW-1:0]]   <= count_ff;
      end
      if (cmd.scan_issue) begin
         rd_members_ff <= members_mem[scan_ff[AW-1:0]];
         rd_size_ff    <= sizes_mem[scan_ff[AW-1:0]];
         rd_idx_ff     <= scan_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_state  = new_state_ff;
   assign rsp_write_cell = write_ff;
   assign rsp_table_full = full_ff;

endmodule

>>> test/testbench.sv
// self-checking testbench for the boundary set id assigner
// predicts each label from its own copy of the set table; needs bsia_pkg and the top level
`timescale 1ns / 1ps

module testbench;
   import bsia_pkg::*;

   localparam int NB     = MAX_NEIGHBORS_DEF;
   localparam int DEPTH  = TABLE_DEPTH_DEF;
   localparam int GL_MAX = 65279;

   typedef logic [ID_W-1:0] id_type;

   // one label as the block reports it
   typedef struct packed {
      id_type new_state;
      logic   write_cell;
      logic   table_full;
   } label_type;

   logic   clock           = 1'b0;
   logic   reset           = 1'b1;
   logic   start           = 1'b0;
   id_type req_neighbor_id = '0;
   logic   req_present     = 1'b0;
   logic   req_last        = 1'b0;
   logic   csr_valid       = 1'b0;
   id_type csr_data        = '0;
   logic   busy;
   logic   rsp_valid;
   id_type rsp_new_state;
   logic   rsp_write_cell;
   logic   rsp_table_full;
   logic   csr_ready;

   boundary_set_id_assigner #(
      .MAX_NEIGHBORS (NB),
      .TABLE_DEPTH   (DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_neighbor_id (req_neighbor_id),
      .req_present     (req_present),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_new_state   (rsp_new_state),
      .rsp_write_cell  (rsp_write_cell),
      .rsp_table_full  (rsp_table_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // predicted labeller state
   id_type    model_limit = '0;
   id_type    gathered [NB];
   int        n_gathered = 0;
   int        n_items    = 0;
   id_type    stored_sets [DEPTH][NB];
   int        stored_size [DEPTH];
   int        n_stored   = 0;
   label_type pending_labels [$];

   // run statistics
   int     label_errors  = 0;
   int     labels_seen   = 0;
   int     items_sent    = 0;
   int     hits_seen     = 0;
   int     full_seen     = 0;
   int     send_idle_pct = 0;
   id_type grain_pool [6];

   // insert one grain id into the sorted set, dropping repeats
   function automatic void add_to_set(id_type id);
      int pos;
      int k;
      pos = 0;
      while (pos < n_gathered && gathered[pos] < id) pos++;
      if (pos < n_gathered && gathered[pos] == id) return;
      if (n_gathered >= NB) return;
      for (k = n_gathered; k > pos; k--) gathered[k] = gathered[k - 1];
      gathered[pos] = id;
      n_gathered++;
   endfunction

   // advance the prediction by one accepted neighbour and queue any label
   function automatic void label_neighbor(id_type id, logic present, logic last);
      label_type lbl;
      int        hit_at;
      int        e;
      int        k;
      bit        same;
      if (n_items < NB) begin
         n_items++;
         if (present && id <= model_limit) add_to_set(id);
      end
      if (!last) return;
      lbl = '0;
      if (n_gathered >= 2) begin
         hit_at = -1;
         for (e = 0; e < n_stored && hit_at < 0; e++) begin
            same = (stored_size[e] == n_gathered);
            for (k = 0; k < n_gathered && same; k++)
               if (stored_sets[e][k] != gathered[k]) same = 0;
            if (same) hit_at = e;
         end
         if (hit_at >= 0) begin
            lbl.new_state  = id_type'(int'(model_limit) + 1 + hit_at);
            lbl.write_cell = 1'b1;
            hits_seen++;
         end else if (n_stored < DEPTH) begin
            for (k = 0; k < n_gathered; k++) stored_sets[n_stored][k] = gathered[k];
            stored_size[n_stored] = n_gathered;
            lbl.new_state  = id_type'(int'(model_limit) + 1 + n_stored);
            lbl.write_cell = 1'b1;
            n_stored++;
         end else begin
            lbl.table_full = 1'b1;
            full_seen++;
         end
      end
      n_gathered = 0;
      n_items    = 0;
      pending_labels = {pending_labels, lbl};
   endfunction

   // one neighbour transfer, with an optional idle gap in front
   task automatic send_neighbor(id_type id, logic present, logic last);
      int gap;
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap   = $urandom_range(1, 4);
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           = 1'b1;
      req_neighbor_id = id;
      req_present     = present;
      req_last        = last;
      do @(posedge clock); while (busy);
      label_neighbor(id, present, last);
      items_sent++;
   endtask

   // drop start and let every outstanding label come back
   task automatic wait_for_idle();
      @(negedge clock);
      start = 1'b0;
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // grain limit register write, only while the block is idle
   task automatic write_grain_limit(id_type value);
      wait_for_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      model_limit = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one neighbourhood of random length: mostly pooled grains, some noise
   task automatic send_random_cell();
      int     len;
      int     pick;
      int     i;
      id_type id;
      logic   present;
      pick = $urandom_range(0, 99);
      len  = (pick < 85) ? $urandom_range(1, 6) :
             (pick < 95) ? $urandom_range(7, 8) : $urandom_range(9, 11);
      for (i = 1; i <= len; i++) begin
         pick    = $urandom_range(0, 99);
         present = 1'b1;
         if (pick < 8) begin
            present = 1'b0;
            id      = id_type'($urandom);
         end else if (pick < 16) begin
            id = id_type'($urandom);
         end else if (pick < 24) begin
            id = id_type'(int'(model_limit) + 1 + $urandom_range(0, 100));
         end else begin
            id = grain_pool[$urandom_range(0, 5)];
         end
         send_neighbor(id, present, i == len);
      end
   endtask

   // reset value of the limit and small sets that leave the cell alone
   task automatic test_skip_cases();
      write_grain_limit('0);
      send_neighbor(16'd0, 1'b1, 1'b1);
      send_neighbor(16'd5, 1'b0, 1'b1);
      send_neighbor(16'd0, 1'b1, 1'b0);
      send_neighbor(16'd0, 1'b1, 1'b0);
      send_neighbor(16'hFFFF, 1'b1, 1'b1);
   endtask

   // new sets, repeats in any order, ids at and above the limit
   task automatic test_hit_and_miss();
      write_grain_limit(16'd1000);
      send_neighbor(16'd5, 1'b1, 1'b0);
      send_neighbor(16'd3, 1'b1, 1'b0);
      send_neighbor(16'd5, 1'b1, 1'b1);
      send_neighbor(16'd3, 1'b1, 1'b0);
      send_neighbor(16'd700, 1'b0, 1'b0);
      send_neighbor(16'd5, 1'b1, 1'b1);
      send_neighbor(16'd2000, 1'b1, 1'b0);
      send_neighbor(16'd3, 1'b1, 1'b1);
      send_neighbor(16'd1000, 1'b1, 1'b0);
      send_neighbor(16'd0, 1'b1, 1'b1);
      send_neighbor(16'd1001, 1'b1, 1'b0);
      send_neighbor(16'd0, 1'b1, 1'b1);
   endtask

   // neighbours past the per-cell limit are dropped, the last marker still closes
   task automatic test_neighbor_overflow();
      int i;
      for (i = 0; i < NB + 1; i++)
         send_neighbor(id_type'(20 + i), 1'b1, i == NB);
   endtask

   // random neighbourhoods around a fresh pool of grain ids
   task automatic test_random_traffic(int idle_pct, int n_items, id_type limit);
      int first;
      write_grain_limit(limit);
      send_idle_pct = idle_pct;
      foreach (grain_pool[i]) grain_pool[i] = id_type'($urandom_range(0, int'(limit)));
      first = items_sent;
      while (items_sent - first < n_items) send_random_cell();
   endtask

   // fill the table with pairs, then mix replayed sets with ones that cannot fit
   task automatic test_table_full();
      int i;
      int e;
      int k;
      write_grain_limit(id_type'(GL_MAX));
      send_idle_pct = 0;
      while (n_stored < DEPTH) begin
         send_neighbor(id_type'($urandom_range(0, GL_MAX)), 1'b1, 1'b0);
         send_neighbor(id_type'($urandom_range(0, GL_MAX)), 1'b1, 1'b1);
      end
      for (i = 0; i < 20; i++) begin
         if ($urandom_range(0, 1)) begin
            e = $urandom_range(0, DEPTH - 1);
            for (k = stored_size[e] - 1; k >= 0; k--)
               send_neighbor(stored_sets[e][k], 1'b1, k == 0);
         end else begin
            send_neighbor(id_type'($urandom_range(0, GL_MAX)), 1'b1, 1'b0);
            send_neighbor(id_type'($urandom_range(0, GL_MAX)), 1'b1, 1'b1);
         end
      end
   endtask

   // compare every label strobe with the oldest prediction
   always @(posedge clock) begin : check_labels
      label_type got;
      label_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_new_state, rsp_write_cell, rsp_table_full};
         labels_seen++;
         if (pending_labels.size() == 0) begin
            $display("%0t unexpected label: expected none, actual state=%h write=%b full=%b",
                     $time, got.new_state, got.write_cell, got.table_full);
            label_errors++;
         end else begin
            want = pending_labels.pop_front();
            if (got !== want) begin
               $display("%0t label mismatch: expected state=%h write=%b full=%b, actual state=%h write=%b full=%b",
                        $time, want.new_state, want.write_cell, want.table_full,
                        got.new_state, got.write_cell, got.table_full);
               label_errors++;
            end
         end
      end
   end

   // test sequence
   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_skip_cases();
      test_hit_and_miss();
      test_neighbor_overflow();
      test_random_traffic(29, 50, 16'd300);
      test_random_traffic(55, 50, id_type'($urandom_range(1, GL_MAX)));
      test_random_traffic(0, 50, id_type'(GL_MAX));
      test_table_full();
      @(negedge clock);
      start = 1'b0;
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      $display("covered %0d neighbour transfers and %0d labels: %0d hits, %0d table-full misses",
               items_sent, labels_seen, hits_seen, full_seen);
      $display("set table ended with %0d of %0d entries used", n_stored, DEPTH);
      if (label_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
